// ----- rtl/wss_pkg.sv -----
// Shared types, constants and fixed-point helpers of the waveshaping saturator.
`default_nettype none

package wss_pkg;

   typedef enum logic [1:0] {
      CURVE_TANH  = 2'd0,
      CURVE_ASYM  = 2'd1,
      CURVE_CUBIC = 2'd2,
      CURVE_FOLD  = 2'd3
   } curve_type;

   localparam logic CSR_CURVE_SELECT = 1'b0;
   localparam logic CSR_BIAS_AMOUNT  = 1'b1;

   localparam int BIAS_WIDTH   = 11;
   localparam int BIAS_MAX     = 1024;
   localparam int BIAS_RESET   = 307;
   localparam int BIAS_SCALE   = 96;

   localparam int ONE_Q16      = 65536;
   localparam int ONE_Q22      = 4194304;
   localparam int Q22_HALF     = 2097152;

   localparam int ROM_WIDTH    = 23;
   localparam int TPOS_SHIFT   = 19;
   localparam int TPOS_HALF    = 262144;
   localparam int ARG_WIDTH    = 21;
   localparam int ARG_SAT      = 524288;

   localparam int RECIP5       = 13421773;
   localparam int RECIP5_SHIFT = 26;
   localparam int RECIP3       = 11184811;
   localparam int RECIP3_SHIFT = 25;

   localparam int PIPE_STAGES  = 8;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] adv;
      logic [PIPE_STAGES-1:0] valid;
   } pipe_ctrl_type;

   // Q22 product of two magnitudes, rounded half up.
   function automatic logic [22:0] mul_q22(input logic [22:0] a, input logic [22:0] b);
      logic [45:0] p;
      p = 46'(a) * 46'(b) + 46'(Q22_HALF);
      return p[44:22];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/wss_tanh_rom.sv -----
// Constant tanh table over [0,8] with two registered read ports.
`default_nettype none

module wss_tanh_rom import wss_pkg::*; #(
   parameter int ENTRIES = 256
) (
   input  wire                               clock,
   input  wire                               en,
   input  wire  [$clog2(ENTRIES+1)-1:0]      addr_lo,
   input  wire  [$clog2(ENTRIES+1)-1:0]      addr_hi,
   output logic [ROM_WIDTH-1:0]              data_lo,
   output logic [ROM_WIDTH-1:0]              data_hi
);

   typedef logic [ROM_WIDTH-1:0] rom_type [ENTRIES+1];

   localparam logic [63:0] A_STEP = (64'd1 << 35) / ENTRIES;

   // Shift-subtract divide for table generation.
   function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // Step e^-2x in Q31 and store round((1-e)/(1+e) * 2^22).
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] r;
      logic [63:0] e;
      logic [63:0] num;
      logic [63:0] den;
      term = 64'd1 << 31;
      sum  = 64'd1 << 31;
      for (int k = 1; k <= 14; k++) begin
         term = udiv((term * A_STEP) >> 31, 64'(k));
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      r = sum;
      e = 64'd1 << 31;
      for (int k = 0; k <= ENTRIES; k++) begin
         num    = ((64'd1 << 31) - e) << 23;
         den    = (64'd1 << 31) + e;
         rom[k] = ROM_WIDTH'(udiv(num + den, den << 1));
         e      = (e * r + (64'd1 << 30)) >> 31;
      end
      return rom;
   endfunction

   localparam rom_type TANH_ROM = build_rom();

   logic [ROM_WIDTH-1:0] lo_ff;
   logic [ROM_WIDTH-1:0] hi_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= TANH_ROM[addr_lo];
         hi_ff <= TANH_ROM[addr_hi];
      end
   end

   assign data_lo = lo_ff;
   assign data_hi = hi_ff;

endmodule

`default_nettype wire

// ----- rtl/wss_pipe_ctrl.sv -----
// Valid bits and per-stage advance enables of the saturator pipeline.
`default_nettype none

module wss_pipe_ctrl import wss_pkg::*; (
   input  wire            clock,
   input  wire            reset,
   input  wire            in_valid,
   input  wire            out_stall,
   output logic           in_stall,
   output pipe_ctrl_type  ctrl
);

   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES-1:0] adv;

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      adv[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !out_stall;
      for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in = valid_ff;
      if (adv[0]) begin
         valid_in[0] = in_valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
         if (adv[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_stall   = !adv[0];
   assign ctrl.adv   = adv;
   assign ctrl.valid = valid_ff;

endmodule

`default_nettype wire

// ----- rtl/waveshaping_saturator_top.sv -----
// Top level of the waveshaping saturator: bias, four shaping curves, output select.
`default_nettype none

// An input transfer is registered through every pipeline stage before its result reaches the rsp channel.
// Throughput: one sample per cycle when rsp_stall is low; stages advance on their own,
// so bubbles collapse and a new sample is taken while a finished result waits.
// Reset clears all valid bits and returns curve_select to tanh and bias_amount
// to 307; the tanh ROM is constant and needs no clearing pass.
module waveshaping_saturator_top import wss_pkg::*; #(
   parameter int TANH_TABLE_ENTRIES = 256,
   parameter int SAMPLE_WIDTH       = 24
) (
   input  wire                              clock,
   input  wire                              reset,
   // input sample channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  signed [SAMPLE_WIDTH-1:0]   req_sample_in,
   // result channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_sample_out,
   // configuration write port
   input  wire                              csr_write,
   input  wire                              csr_index,
   input  wire  [BIAS_WIDTH-1:0]            csr_wdata
);

   localparam int W  = SAMPLE_WIDTH;
   localparam int N  = TANH_TABLE_ENTRIES;
   localparam int BW = W + 2;                 // biased sample, signed
   localparam int MW = W + 1;                 // its magnitude
   localparam int EW = (MW > 20) ? MW : 20;   // magnitude widened for clamping
   localparam int AW = $clog2(N + 1);         // ROM address
   localparam int UW = ARG_WIDTH + AW;        // table position
   localparam int IW = UW - TPOS_SHIFT;       // integer part of the position

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   curve_type             curve_ff;
   logic [BIAS_WIDTH-1:0] bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_ff <= CURVE_TANH;
         bias_ff  <= BIAS_WIDTH'(BIAS_RESET);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CURVE_SELECT: curve_ff <= curve_type'(csr_wdata[1:0]);
            CSR_BIAS_AMOUNT:  bias_ff  <= csr_wdata;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: one valid bit and one advance enable per stage
   // ---------------------------------------------------------------------
   pipe_ctrl_type ctrl;

   wss_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .in_stall  (req_stall),
      .ctrl      (ctrl)
   );

   // ---------------------------------------------------------------------
   // Stage 1: add the bias, 1.5 * bias_amount, which is bias * 96 in Q.16.
   // Bias values above one saturate to one.
   // ---------------------------------------------------------------------
   logic [BIAS_WIDTH-1:0] bias_sat;
   logic [16:0]           bias_off;
   logic [BW-1:0]         s1_b_in;
   logic [BW-1:0]         s1_b_ff;

   always_comb begin
      bias_sat = (bias_ff > BIAS_WIDTH'(BIAS_MAX)) ? BIAS_WIDTH'(BIAS_MAX) : bias_ff;
      bias_off = 17'(bias_sat) * 17'(BIAS_SCALE);
      s1_b_in  = BW'(req_sample_in) + BW'(bias_off);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[0]) begin
         s1_b_ff <= s1_b_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: magnitude and sign. Clamp the tanh argument at 8.0, where the
   // table saturates anyway, so the asymmetric scaling stays narrow. Clamp
   // the cubic input to one and move it to Q22. The fold is done here in
   // closed form: shift by one, wrap with period four, reflect.
   // ---------------------------------------------------------------------
   logic [BW-1:0]        mag_full;
   logic [EW-1:0]        mag;
   logic [17:0]          fold_u;
   logic [18:0]          fold_r;
   logic                 s2_neg_in;
   logic [19:0]          s2_mc_in;
   logic [22:0]          s2_v_in;
   logic [22:0]          s2_mq_in;
   logic [23:0]          s2_fold_in;
   logic                 s2_neg_ff;
   logic [19:0]          s2_mc_ff;
   logic [22:0]          s2_v_ff;
   logic [22:0]          s2_mq_ff;
   logic [23:0]          s2_fold_ff;

   always_comb begin
      s2_neg_in = s1_b_ff[BW-1];
      mag_full  = s2_neg_in ? (~s1_b_ff + BW'(1)) : s1_b_ff;
      mag       = EW'(mag_full[MW-1:0]);
      s2_mc_in  = (mag >= EW'(ARG_SAT)) ? 20'(ARG_SAT) : mag[19:0];
      // 12/5 on the negative side, 8/5 on the positive side, rounded
      s2_v_in   = s2_neg_in ? (23'(s2_mc_in) * 23'd12 + 23'd2)
                            : (23'(s2_mc_in) * 23'd8 + 23'd2);
      s2_mq_in  = (mag >= EW'(ONE_Q16)) ? 23'(ONE_Q22) : 23'({mag[15:0], 6'b000000});
      fold_u    = s1_b_ff[17:0] + 18'(ONE_Q16);
      fold_r    = (fold_u <= 18'(2 * ONE_Q16)) ? (19'(fold_u) - 19'(ONE_Q16))
                                               : (19'(3 * ONE_Q16) - 19'(fold_u));
      s2_fold_in = {fold_r[17:0], 6'b000000};
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[1]) begin
         s2_neg_ff  <= s2_neg_in;
         s2_mc_ff   <= s2_mc_in;
         s2_v_ff    <= s2_v_in;
         s2_mq_ff   <= s2_mq_in;
         s2_fold_ff <= s2_fold_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: divide by five through a reciprocal multiply (exact for the
   // clamped range); first cubic product y*y.
   // ---------------------------------------------------------------------
   logic [46:0]          p5;
   logic [ARG_WIDTH-1:0] s3_q5_in;
   logic [22:0]          s3_sq_in;
   logic                 s3_neg_ff;
   logic [19:0]          s3_mc_ff;
   logic [ARG_WIDTH-1:0] s3_q5_ff;
   logic [22:0]          s3_mq_ff;
   logic [22:0]          s3_sq_ff;
   logic [23:0]          s3_fold_ff;

   always_comb begin
      p5       = 47'(s2_v_ff) * 47'(RECIP5);
      s3_q5_in = p5[RECIP5_SHIFT +: ARG_WIDTH];
      s3_sq_in = mul_q22(s2_mq_ff, s2_mq_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[2]) begin
         s3_neg_ff  <= s2_neg_ff;
         s3_mc_ff   <= s2_mc_ff;
         s3_q5_ff   <= s3_q5_in;
         s3_mq_ff   <= s2_mq_ff;
         s3_sq_ff   <= s3_sq_in;
         s3_fold_ff <= s2_fold_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: table position |x| * N / 8 with a 19-bit fraction, and the
   // ROM read of both neighbors. Past the end, point both reads at the
   // last entry and drop the fraction. Second cubic product y*y*y.
   // ---------------------------------------------------------------------
   logic [ARG_WIDTH-1:0]  tanh_arg;
   logic [UW-1:0]         tpos;
   logic [IW-1:0]         tidx;
   logic                  tsat;
   logic [AW-1:0]         addr_lo;
   logic [AW-1:0]         addr_hi;
   logic [TPOS_SHIFT-1:0] s4_frac_in;
   logic [22:0]           s4_c3_in;
   logic                  s4_neg_ff;
   logic [TPOS_SHIFT-1:0] s4_frac_ff;
   logic [22:0]           s4_c3_ff;
   logic [22:0]           s4_mq_ff;
   logic [23:0]           s4_fold_ff;
   logic [ROM_WIDTH-1:0]  rom_lo;
   logic [ROM_WIDTH-1:0]  rom_hi;

   always_comb begin
      tanh_arg   = (curve_ff == CURVE_ASYM) ? s3_q5_ff : ARG_WIDTH'(s3_mc_ff);
      tpos       = UW'(tanh_arg) * UW'(N);
      tidx       = tpos[UW-1:TPOS_SHIFT];
      tsat       = (tidx >= IW'(N));
      addr_lo    = tsat ? AW'(N) : tidx[AW-1:0];
      addr_hi    = tsat ? AW'(N) : (tidx[AW-1:0] + AW'(1));
      s4_frac_in = tsat ? '0 : tpos[TPOS_SHIFT-1:0];
      s4_c3_in   = mul_q22(s3_sq_ff, s3_mq_ff);
   end

   wss_tanh_rom #(
      .ENTRIES (N)
   ) u_rom (
      .clock   (clock),
      .en      (ctrl.adv[3]),
      .addr_lo (addr_lo),
      .addr_hi (addr_hi),
      .data_lo (rom_lo),
      .data_hi (rom_hi)
   );

   always_ff @(posedge clock) begin
      if (ctrl.adv[3]) begin
         s4_neg_ff  <= s3_neg_ff;
         s4_frac_ff <= s4_frac_in;
         s4_c3_ff   <= s4_c3_in;
         s4_mq_ff   <= s3_mq_ff;
         s4_fold_ff <= s3_fold_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5: interpolation product (slope times fraction); cubic
   // y1 = y - y^3/3, the divide by three again a reciprocal multiply.
   // ---------------------------------------------------------------------
   logic [22:0]          slope;
   logic [47:0]          p3;
   logic [41:0]          s5_dprod_in;
   logic [22:0]          s5_y1_in;
   logic                 s5_neg_ff;
   logic [41:0]          s5_dprod_ff;
   logic [ROM_WIDTH-1:0] s5_lo_ff;
   logic [22:0]          s5_y1_ff;
   logic [23:0]          s5_fold_ff;

   always_comb begin
      slope       = (rom_hi > rom_lo) ? (rom_hi - rom_lo) : '0;
      s5_dprod_in = 42'(slope) * 42'(s4_frac_ff);
      p3          = 48'(24'(s4_c3_ff) + 24'd1) * 48'(RECIP3);
      s5_y1_in    = s4_mq_ff - p3[RECIP3_SHIFT +: 23];
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[4]) begin
         s5_neg_ff   <= s4_neg_ff;
         s5_dprod_ff <= s5_dprod_in;
         s5_lo_ff    <= rom_lo;
         s5_y1_ff    <= s5_y1_in;
         s5_fold_ff  <= s4_fold_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 6: finish the interpolation, rounding half up; cubic y1*y1.
   // ---------------------------------------------------------------------
   logic [41:0]          dround;
   logic [22:0]          s6_t_in;
   logic [22:0]          s6_y2_in;
   logic                 s6_neg_ff;
   logic [22:0]          s6_t_ff;
   logic [22:0]          s6_y1_ff;
   logic [22:0]          s6_y2_ff;
   logic [23:0]          s6_fold_ff;

   always_comb begin
      dround   = s5_dprod_ff + 42'(TPOS_HALF);
      s6_t_in  = s5_lo_ff + dround[TPOS_SHIFT +: 23];
      s6_y2_in = mul_q22(s5_y1_ff, s5_y1_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[5]) begin
         s6_neg_ff  <= s5_neg_ff;
         s6_t_ff    <= s6_t_in;
         s6_y1_ff   <= s5_y1_ff;
         s6_y2_ff   <= s6_y2_in;
         s6_fold_ff <= s5_fold_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 7: asymmetric curve divides by 1.6, that is times 5/8 rounded;
   // restore the sign of the tanh result. Cubic y1^3.
   // ---------------------------------------------------------------------
   logic [25:0]          t58;
   logic [22:0]          tmag;
   logic [23:0]          s7_tanh_in;
   logic [22:0]          s7_n3_in;
   logic                 s7_neg_ff;
   logic [23:0]          s7_tanh_ff;
   logic [22:0]          s7_y1_ff;
   logic [22:0]          s7_n3_ff;
   logic [23:0]          s7_fold_ff;

   always_comb begin
      t58        = (26'(s6_t_ff) * 26'd5 + 26'd4) >> 3;
      tmag       = (curve_ff == CURVE_ASYM) ? t58[22:0] : s6_t_ff;
      s7_tanh_in = s6_neg_ff ? (24'd0 - 24'(tmag)) : 24'(tmag);
      s7_n3_in   = mul_q22(s6_y2_ff, s6_y1_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[6]) begin
         s7_neg_ff  <= s6_neg_ff;
         s7_tanh_ff <= s7_tanh_in;
         s7_y1_ff   <= s6_y1_ff;
         s7_n3_ff   <= s7_n3_in;
         s7_fold_ff <= s6_fold_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 8: cubic z = (3*y1 - y1^3 + 1) / 2 with its sign, then select the
   // curve and fit the Q1.22 result to the sample width.
   // ---------------------------------------------------------------------
   logic [24:0]   zsum;
   logic [23:0]   cubic_y;
   logic [23:0]   shaped;
   logic [31:0]   shaped_ext;
   logic [W-1:0]  s8_out_in;
   logic [W-1:0]  s8_out_ff;

   always_comb begin
      zsum    = 25'(s7_y1_ff) * 25'd3 - 25'(s7_n3_ff) + 25'd1;
      cubic_y = s7_neg_ff ? (24'd0 - zsum[24:1]) : zsum[24:1];
      case (curve_ff)
         CURVE_TANH, CURVE_ASYM: shaped = s7_tanh_ff;
         CURVE_CUBIC:            shaped = cubic_y;
         default:                shaped = s7_fold_ff;
      endcase
      shaped_ext = 32'($signed(shaped));
      s8_out_in  = shaped_ext[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv[7]) begin
         s8_out_ff <= s8_out_in;
      end
   end

   assign rsp_valid      = ctrl.valid[PIPE_STAGES-1];
   assign rsp_sample_out = s8_out_ff;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench of the waveshaping saturator: random streams under random back-pressure.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wss_pkg::*;

   localparam int TANH_N      = 256;
   localparam int SW          = 24;
   localparam int CYCLE_LIMIT = 400000;
   // Items per random phase; 16 phases give the bulk of the stream.
   localparam int PHASE_ITEMS = 80;
   // Settle wait before the verdict, sized from the pipeline depth of 8.
   localparam int SETTLE      = 16;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic signed [SW-1:0] req_sample_in  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic signed [SW-1:0] rsp_sample_out;
   logic                 csr_write      = 1'b0;
   logic                 csr_index      = CSR_CURVE_SELECT;
   logic [BIAS_WIDTH-1:0] csr_wdata     = '0;

   // Shadow copy of the configuration, as the block holds it after reset.
   curve_type            cfg_curve = CURVE_TANH;
   logic [BIAS_WIDTH-1:0] cfg_bias = BIAS_WIDTH'(BIAS_RESET);

   longint unsigned      tanh_table [0:TANH_N];

   logic signed [SW-1:0] samples_q [$];   // samples waiting to be offered
   logic [SW-1:0]        shaped_q  [$];   // predicted outputs, oldest first

   int                   sent_count     = 0;
   int                   rsp_count      = 0;
   int                   gap_left       = 0;
   int                   hold_left      = 0;
   bit                   long_hold_done = 1'b0;
   int                   mismatch_count = 0;
   int                   cycle_count    = 0;
   logic [SW-1:0]        want_sample;

   // Corner samples: full-scale extremes, zero, plus one, the fold turning points
   // at plus and minus three, and the input that lands exactly on a tanh argument
   // of 8.0 under the reset bias of 307 (307 * 96 = 29472).
   logic signed [SW-1:0] corner [7] = '{-24'sd8388608, 24'sd8388607, 24'sd0, 24'sd65536,
                                         24'sd196608, -24'sd196608, 24'sd494816};

   waveshaping_saturator_top #(
      .TANH_TABLE_ENTRIES(TANH_N),
      .SAMPLE_WIDTH(SW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Build the tanh table: step e^-2x in Q31 by a series for e^-(16/N),
   // then round (1-e)/(1+e) into Q22 at every point.
   function automatic void build_tanh_table();
      longint unsigned tbl_step, term, ratio, e, num, den;
      longint          sum;
      int              k;
      tbl_step = (64'd1 << 35) / TANH_N;
      term     = 64'd1 << 31;
      sum      = 64'sd2147483648;
      for (k = 1; k <= 14; k++) begin
         term = ((term * tbl_step) >> 31) / k;
         if (k % 2 == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      ratio = sum;
      e     = 64'd1 << 31;
      for (k = 0; k <= TANH_N; k++) begin
         num = ((64'd1 << 31) - e) << 23;
         den = (64'd1 << 31) + e;
         tanh_table[k] = (num + den) / (2 * den);
         e = (e * ratio + (64'd1 << 30)) >> 31;
      end
   endfunction

   // tanh of a Q16 magnitude, as a Q22 magnitude; saturate at and beyond 8.0.
   function automatic longint unsigned tanh_lookup(input longint unsigned mag);
      longint unsigned pos, idx, frac, lo, hi, d;
      pos  = mag * TANH_N;
      idx  = pos >> TPOS_SHIFT;
      frac = pos & ((64'd1 << TPOS_SHIFT) - 1);
      if (idx >= TANH_N) return tanh_table[TANH_N];
      lo = tanh_table[idx];
      hi = tanh_table[idx + 1];
      d  = (hi > lo) ? hi - lo : 0;
      return lo + ((d * frac + (64'd1 << (TPOS_SHIFT - 1))) >> TPOS_SHIFT);
   endfunction

   function automatic longint unsigned q22_product(input longint unsigned a,
                                                   input longint unsigned b);
      return (a * b + (64'd1 << 21)) >> 22;
   endfunction

   // Clamp to one, then two cubic stages on the Q22 magnitude; restore the sign.
   function automatic longint cubic_clip(input longint b);
      longint unsigned m, y1, n3, z;
      m = (b < 0) ? -b : b;
      if (m > ONE_Q16) m = ONE_Q16;
      m  = m << 6;
      y1 = m - (q22_product(q22_product(m, m), m) + 1) / 3;
      n3 = q22_product(q22_product(y1, y1), y1);
      z  = (3 * y1 - n3 + 1) >> 1;
      return (b < 0) ? -longint'(z) : longint'(z);
   endfunction

   // Triangle fold with period four, in closed form.
   function automatic longint fold_triangle(input longint b);
      longint u, y;
      u = (b + ONE_Q16) & 64'h3FFFF;
      y = (u <= 2 * ONE_Q16) ? u - ONE_Q16 : 3 * ONE_Q16 - u;
      return y * 64;
   endfunction

   // Shaped output of one sample under the current shadow configuration.
   function automatic logic [SW-1:0] shape_sample(input logic signed [SW-1:0] s);
      longint          x, b, y;
      longint unsigned m;
      int unsigned     bias;
      x    = longint'(s);
      bias = (cfg_bias > BIAS_MAX) ? BIAS_MAX : cfg_bias;
      b    = x + longint'(bias) * BIAS_SCALE;
      m    = (b < 0) ? -b : b;
      case (cfg_curve)
         CURVE_TANH: begin
            y = tanh_lookup(m);
            if (b < 0) y = -y;
         end
         CURVE_ASYM: begin
            if (b >= 0) y = (tanh_lookup((m * 8 + 2) / 5) * 5 + 4) >> 3;
            else y = -longint'((tanh_lookup((m * 12 + 2) / 5) * 5 + 4) >> 3);
         end
         CURVE_CUBIC: y = cubic_clip(b);
         default: y = fold_triangle(b);
      endcase
      return y[SW-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Most samples sit near the knee of the curves; a quarter span the full range.
   function automatic logic signed [SW-1:0] random_sample();
      case ($urandom_range(0, 3))
         0:       return SW'($urandom);
         1, 2:    return SW'($urandom_range(0, 2097151) - 1048576);
         default: return SW'($urandom_range(0, 262143) - 131072);
      endcase
   endfunction

   // Idle length for either side: mostly none or short, a few long, and
   // every third window of transfers runs with no idling at all.
   function automatic int pick_idle(input int count, input int offset);
      int r;
      if (((count + offset) / 160) % 3 == 1) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Wait until every queued sample is sent and every result has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (samples_q.size() != 0 || req_valid || shaped_q.size() != 0);
   endtask

   // Write both registers on back-to-back edges; hold the write enable high
   // across them so it is never lowered and raised in one step.
   task automatic set_mode(input curve_type curve, input logic [BIAS_WIDTH-1:0] bias);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_CURVE_SELECT;
      csr_wdata <= BIAS_WIDTH'(curve);
      @(posedge clock);
      csr_index <= CSR_BIAS_AMOUNT;
      csr_wdata <= bias;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_curve = curve;
      cfg_bias  = bias;
   endtask

   // ------------------------------------------------------------------
   // Driver: offer samples from the queue, hold a stalled transfer, and
   // predict the output of every sample at the edge it is accepted.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            shaped_q.push_back(shape_sample(req_sample_in));
         // Advance only when the slot is empty or its transfer just completed.
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (samples_q.size() > 0) begin
               req_valid     <= 1'b1;
               req_sample_in <= samples_q.pop_front();
               sent_count++;
               gap_left = pick_idle(sent_count, 0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: check each result transfer against the oldest prediction,
   // then choose the stall for the next cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (shaped_q.size() == 0) begin
               $display("%0t: sample_out %0d arrived with nothing expected",
                        $time, rsp_sample_out);
               mismatch_count++;
            end else begin
               want_sample = shaped_q.pop_front();
               if (rsp_sample_out !== want_sample) begin
                  $display("%0t: sample_out expected %0d actual %0d",
                           $time, $signed(want_sample), rsp_sample_out);
                  mismatch_count++;
               end
            end
         end
         // Once, early in the random stream, hold off for a long stretch so
         // the pipeline fills and the block must stall its input.
         if (hold_left > 0) hold_left--;
         else if (!long_hold_done && rsp_count >= 40) begin
            long_hold_done = 1'b1;
            hold_left = 200;
         end else hold_left = pick_idle(rsp_count, 80);
         rsp_stall <= (hold_left > 0);
      end
   end

   // Drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence: directed corners under four settings, then random phases
   // over every curve and the bias extremes.
   // ------------------------------------------------------------------
   initial begin
      int                    p, k;
      logic [BIAS_WIDTH-1:0] bias;
      build_tanh_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings first, then fold with no bias for the
      // turning points, asymmetric tanh with a bias above one, cubic with no bias.
      for (p = 0; p < 4; p++) begin
         case (p)
            1: set_mode(CURVE_FOLD, '0);
            2: set_mode(CURVE_ASYM, '1);
            3: set_mode(CURVE_CUBIC, '0);
            default: ;
         endcase
         @(negedge clock);
         foreach (corner[i]) samples_q.push_back(corner[i]);
         wait_idle();
      end

      // Random: each curve under zero bias, full bias, saturated bias, random bias.
      for (p = 0; p < 16; p++) begin
         case (p / 4)
            0:       bias = '0;
            1:       bias = BIAS_WIDTH'(BIAS_MAX);
            2:       bias = '1;
            default: bias = BIAS_WIDTH'($urandom_range(0, 2047));
         endcase
         set_mode(curve_type'(p % 4), bias);
         @(negedge clock);
         for (k = 0; k < PHASE_ITEMS; k++) samples_q.push_back(random_sample());
         wait_idle();
      end

      // Catch any stray result before the verdict.
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
